// ----- hw/rtl/utf8_stream_transcoder_assert.svh -----
// Assertion macros shared by the transcoder RTL.
// Needs no package; the guard keeps repeated includes harmless.
`ifndef UTF8_STREAM_TRANSCODER_ASSERT_SVH
`define UTF8_STREAM_TRANSCODER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define UTF8ST_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("utf8 transcoder assertion failed");

// Checked at every clock edge, reset included.
`define UTF8ST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("utf8 transcoder assertion failed");

`else

`define UTF8ST_ASSERT_RST(lbl, clk, rst, prop)
`define UTF8ST_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hw/rtl/utf8st_pkg.sv -----
// Shared types and constants of the UTF-8 stream transcoder.
// Used by utf8st_decode and utf8_stream_transcoder; depends on nothing.
`timescale 1ns / 1ps

package utf8st_pkg;

   localparam int UnitWidth = 21;

   // Result status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CONT  = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   // Output format register values.
   localparam logic FORMAT_UTF32 = 1'b0;
   localparam logic FORMAT_UTF16 = 1'b1;

   // Lead byte classification masks and patterns.
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] PAYLOAD2_MASK = 8'h1F;
   localparam logic [7:0] PAYLOAD3_MASK = 8'h0F;
   localparam logic [7:0] PAYLOAD4_MASK = 8'h07;
   localparam logic [1:0] CONT_PREFIX = 2'b10;

   // Surrogate pair construction.
   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;
   localparam logic [UnitWidth-1:0] SUPPLEMENTARY_BASE = 21'h10000;
   localparam logic [9:0] SURR_LOW_MASK = 10'h3FF;

   typedef struct packed {
      logic [1:0]           remaining;
      logic [2:0]           seq_len;
      logic [UnitWidth-1:0] partial;
      logic                 cont_error;
   } dec_state_type;

   typedef struct packed {
      logic [UnitWidth-1:0] unit;
      logic [1:0]           status;
      logic [2:0]           consumed;
      logic                 last_of_run;
   } result_type;

   // Number of results held or produced: 0, 1 or 2.
   typedef logic [1:0] res_count_type;

endpackage

// ----- hw/rtl/utf8st_decode.sv -----
// Combinational decode of one stream byte against the open sequence.
// Depends on utf8st_pkg for the state and result structs.
`timescale 1ns / 1ps

module utf8st_decode
   import utf8st_pkg::*;
(
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   input  logic          out_format,
   input  dec_state_type cur_state,
   output dec_state_type next_state,
   output result_type    res0,
   output result_type    res1,
   output res_count_type res_count
);

   logic [2:0]           lead_len;
   logic [UnitWidth-1:0] lead_partial;
   logic [UnitWidth-1:0] cont_partial;
   logic                 cont_err;
   logic [1:0]           cont_remaining;
   logic [2:0]           got_bytes;
   logic [UnitWidth-1:0] emit_cp;
   logic [1:0]           emit_status;
   logic [2:0]           emit_len;
   logic [UnitWidth-1:0] supp_offset;
   logic [15:0]          high_unit;
   logic [15:0]          low_unit;
   logic                 emit_pair;

   always_comb begin
      priority if (data_byte[7] == 1'b0) begin
         lead_len = 3'd1;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         lead_len = 3'd2;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         lead_len = 3'd3;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         lead_len = 3'd4;
      end else begin
         lead_len = 3'd0;
      end
   end

   always_comb begin
      unique case (lead_len)
         3'd2:    lead_partial = {13'd0, data_byte & PAYLOAD2_MASK};
         3'd3:    lead_partial = {13'd0, data_byte & PAYLOAD3_MASK};
         default: lead_partial = {13'd0, data_byte & PAYLOAD4_MASK};
      endcase
   end

   assign cont_partial   = {cur_state.partial[UnitWidth-7:0], data_byte[5:0]};
   assign cont_err       = cur_state.cont_error | (data_byte[7:6] != CONT_PREFIX);
   assign cont_remaining = cur_state.remaining - 2'd1;
   assign got_bytes      = cur_state.seq_len - {1'b0, cont_remaining};

   // A completed sequence is either the raw ASCII byte or the gathered value.
   assign emit_cp     = (cur_state.remaining == 2'd0) ? {13'd0, data_byte} : cont_partial;
   assign emit_status = (cur_state.remaining != 2'd0 && cont_err) ? STATUS_BAD_CONT
                                                                   : STATUS_OK;
   assign emit_len    = (cur_state.remaining == 2'd0) ? 3'd1 : cur_state.seq_len;

   // Supplementary code points split into a surrogate pair in UTF-16 mode.
   assign emit_pair   = (out_format == FORMAT_UTF16) && (emit_cp[UnitWidth-1:16] != '0);
   assign supp_offset = emit_cp - SUPPLEMENTARY_BASE;
   assign high_unit   = SURR_HIGH_BASE | {5'd0, supp_offset[UnitWidth-1:10]};
   assign low_unit    = SURR_LOW_BASE | {6'd0, supp_offset[9:0] & SURR_LOW_MASK};

   always_comb begin
      logic emit;
      emit       = 1'b0;
      next_state = '0;
      res0       = '0;
      res1       = '0;
      res_count  = 2'd0;

      if (cur_state.remaining == 2'd0) begin
         if (lead_len == 3'd0) begin
            res0      = '{unit: '0, status: STATUS_BAD_LEAD, consumed: 3'd1,
                          last_of_run: 1'b1};
            res_count = 2'd1;
         end else if (lead_len == 3'd1) begin
            emit = 1'b1;
         end else if (last_byte) begin
            res0      = '{unit: '0, status: STATUS_TRUNCATED, consumed: 3'd1,
                          last_of_run: 1'b1};
            res_count = 2'd1;
         end else begin
            next_state = '{remaining: lead_len[1:0] - 2'd1, seq_len: lead_len,
                           partial: lead_partial, cont_error: 1'b0};
         end
      end else begin
         if (cont_remaining == 2'd0) begin
            emit = 1'b1;
         end else if (last_byte) begin
            res0      = '{unit: '0, status: STATUS_TRUNCATED, consumed: got_bytes,
                          last_of_run: 1'b1};
            res_count = 2'd1;
         end else begin
            next_state = '{remaining: cont_remaining, seq_len: cur_state.seq_len,
                           partial: cont_partial, cont_error: cont_err};
         end
      end

      if (emit) begin
         if (emit_pair) begin
            res0      = '{unit: {5'd0, high_unit}, status: emit_status, consumed: 3'd0,
                          last_of_run: 1'b0};
            res1      = '{unit: {5'd0, low_unit}, status: emit_status, consumed: emit_len,
                          last_of_run: 1'b1};
            res_count = 2'd2;
         end else begin
            res0      = '{unit: emit_cp, status: emit_status, consumed: emit_len,
                          last_of_run: 1'b1};
            res_count = 2'd1;
         end
      end
   end

endmodule

// ----- hw/rtl/utf8_stream_transcoder.sv -----
// UTF-8 stream transcoder top level: one byte per request, UTF-32 or UTF-16 results.
// Pipeline: two register stages, the input register and the result buffer. A result
// is valid on rsp_ once decode has written it into the buffer and can then be taken.
// Throughput: one byte per cycle while the result side keeps up; a surrogate pair holds
// the port for both its units and the next byte waits in the input register behind it.
// Reset (synchronous, active high) clears the open sequence, the buffers and the
// output format, which returns to UTF-32.
`timescale 1ns / 1ps
`include "utf8_stream_transcoder_assert.svh"

module utf8_stream_transcoder
   import utf8st_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_last_byte,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [UnitWidth-1:0] rsp_unit,
   output logic [1:0]           rsp_status,
   output logic [2:0]           rsp_consumed_bytes,
   output logic                 rsp_last_of_run,

   input  logic                 csr_write_enable,
   input  logic                 csr_write_data
);

   // The input register holds one request byte. The decode stage reads it together
   // with the open sequence state and writes all results that the byte causes into
   // the result buffer in one step, so the buffer must drain to empty first.

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff, in_byte_in;
   logic          in_last_ff, in_last_in;

   logic          format_ff, format_in;
   dec_state_type state_ff, state_in;

   result_type    slot0_ff, slot0_in;
   result_type    slot1_ff, slot1_in;
   res_count_type count_ff, count_in;

   dec_state_type dec_next;
   result_type    dec_res0;
   result_type    dec_res1;
   res_count_type dec_count;

   logic          rsp_pop;
   logic          buf_room;
   logic          dec_fire;
   logic          req_fire;

   utf8st_decode u_decode (
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .out_format (format_ff),
      .cur_state  (state_ff),
      .next_state (dec_next),
      .res0       (dec_res0),
      .res1       (dec_res1),
      .res_count  (dec_count)
   );

   // The buffer has room for a full pair only when it is empty after this cycle's pop.
   assign rsp_pop  = rsp_valid && rsp_ready;
   assign buf_room = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_ready);
   assign dec_fire = in_valid_ff && buf_room;

   // The input register frees up whenever its byte moves into decode.
   assign req_ready = !in_valid_ff || dec_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_data_byte;
         in_last_in  = req_last_byte;
      end else if (dec_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // The user must write configuration only while idle, so it never races a decode; the block does not enforce this.
   assign format_in = csr_write_enable ? csr_write_data : format_ff;
   assign state_in  = dec_fire ? dec_next : state_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (dec_fire) begin
         slot0_in = dec_res0;
         slot1_in = dec_res1;
         count_in = dec_count;
      end else if (rsp_pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         format_ff   <= FORMAT_UTF32;
         state_ff    <= '0;
         count_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         format_ff   <= format_in;
         state_ff    <= state_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   assign rsp_valid          = (count_ff != 2'd0);
   assign rsp_unit           = slot0_ff.unit;
   assign rsp_status         = slot0_ff.status;
   assign rsp_consumed_bytes = slot0_ff.consumed;
   assign rsp_last_of_run    = slot0_ff.last_of_run;

   // The buffer never holds more than one surrogate pair.
   `UTF8ST_ASSERT_RST(a_count_range, clock, reset, count_ff != 2'd3)

   // A high surrogate on the port always has its low partner queued behind it.
   `UTF8ST_ASSERT_RST(a_pair_buffered, clock, reset,
      (rsp_valid && !rsp_last_of_run) |-> (count_ff == 2'd2))

   // A byte that cannot enter decode stays in the input register.
   `UTF8ST_ASSERT_RST(a_stall_holds, clock, reset,
      (in_valid_ff && !dec_fire) |=> (in_valid_ff && $stable(in_byte_ff)))

   // An open sequence always has at least one byte already received.
   `UTF8ST_ASSERT_RST(a_state_consistent, clock, reset,
      (state_ff.remaining == 2'd0) || (state_ff.seq_len > {1'b0, state_ff.remaining}))

   // Popping the high unit promotes the queued low unit.
   `UTF8ST_ASSERT_RST(a_pair_shift, clock, reset,
      (rsp_pop && count_ff == 2'd2) |=> (rsp_valid && rsp_unit == $past(slot1_ff.unit)))

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for utf8_stream_transcoder: UTF-8 bytes in, UTF-32 or UTF-16 out.
// A built-in decoder predicts every result; depends only on utf8st_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
   import utf8st_pkg::*;

   // The slowest correct run is far below this: about 1250 requests, two results each at
   // most, random stalls on both sides and one long hold-off on the result side.
   localparam int CycleLimit   = 400000;
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 6;
   localparam int IdlePercent  = 13;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_data_byte;
   logic                 req_last_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [UnitWidth-1:0] rsp_unit;
   logic [1:0]           rsp_status;
   logic [2:0]           rsp_consumed_bytes;
   logic                 rsp_last_of_run;
   logic                 csr_write_enable;
   logic                 csr_write_data;

   // Decoder state as the testbench tracks it, updated once per accepted request.
   logic [1:0]           dec_remaining;
   logic [2:0]           dec_length;
   logic [UnitWidth-1:0] dec_partial;
   logic                 dec_cont_error;
   logic                 out_format;

   // Results that the decoder must still deliver, oldest first.
   result_type           pending_units[$];
   result_type           want;
   result_type           got;

   int                   fail_count;
   int                   cycle_count;
   bit                   no_idle;
   bit                   hold_request;
   int                   hold_left;

   utf8_stream_transcoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_unit           (rsp_unit),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A hard stop in case the block hangs or loses a handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // Sequence length announced by a lead byte; zero means the byte cannot start one.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      if (!b[7])                                 return 3'd1;
      else if ((b & LEAD2_MASK) == LEAD2_CODE)   return 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE)   return 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE)   return 3'd4;
      return 3'd0;
   endfunction

   task automatic push_unit(input logic [UnitWidth-1:0] unit, input logic [1:0] status,
                            input logic [2:0] consumed, input logic last);
      result_type r;
      r.unit        = unit;
      r.status      = status;
      r.consumed    = consumed;
      r.last_of_run = last;
      pending_units.push_back(r);
   endtask

   task automatic clear_decoder();
      dec_remaining  = '0;
      dec_length     = '0;
      dec_partial    = '0;
      dec_cont_error = 1'b0;
   endtask

   // A finished code point leaves as one unit, or as a surrogate pair when UTF-16 output
   // is selected and the value lies above the basic plane. Each half of the pair is 16 bits
   // wide; for values beyond the Unicode range the high unit falls outside D800 to DBFF.
   task automatic emit_code_point(input logic [UnitWidth-1:0] cp, input logic [1:0] status,
                                  input logic [2:0] len);
      logic [UnitWidth-1:0] offset;
      logic [15:0]          high_unit;
      logic [15:0]          low_unit;
      if (out_format == FORMAT_UTF16 && cp >= SUPPLEMENTARY_BASE) begin
         offset    = cp - SUPPLEMENTARY_BASE;
         high_unit = SURR_HIGH_BASE | 16'(offset >> 10);
         low_unit  = SURR_LOW_BASE | {6'd0, offset[9:0] & SURR_LOW_MASK};
         push_unit(UnitWidth'(high_unit), status, 3'd0, 1'b0);
         push_unit(UnitWidth'(low_unit), status, len, 1'b1);
      end else begin
         push_unit(cp, status, len, 1'b1);
      end
   endtask

   // Advances the tracked decoder by one accepted byte and queues what it produces.
   task automatic decode_byte(input logic [7:0] b, input logic last);
      logic [2:0]           len;
      logic [UnitWidth-1:0] cp;
      logic [1:0]           status;
      if (dec_remaining == 2'd0) begin
         len = lead_length(b);
         if (len == 3'd0) begin
            // A stray continuation byte or an 11111xxx byte: reported on its own.
            clear_decoder();
            push_unit('0, STATUS_BAD_LEAD, 3'd1, 1'b1);
         end else if (len == 3'd1) begin
            clear_decoder();
            emit_code_point(UnitWidth'(b), STATUS_OK, 3'd1);
         end else begin
            case (len)
               3'd2:    dec_partial = UnitWidth'(b & PAYLOAD2_MASK);
               3'd3:    dec_partial = UnitWidth'(b & PAYLOAD3_MASK);
               default: dec_partial = UnitWidth'(b & PAYLOAD4_MASK);
            endcase
            dec_length     = len;
            dec_remaining  = 2'(len - 3'd1);
            dec_cont_error = 1'b0;
            if (last) begin
               // The stream ended right after a lead byte.
               clear_decoder();
               push_unit('0, STATUS_TRUNCATED, 3'd1, 1'b1);
            end
         end
      end else begin
         // A byte without the 10 prefix still contributes its low six bits.
         if (b[7:6] != CONT_PREFIX) dec_cont_error = 1'b1;
         dec_partial   = {dec_partial[UnitWidth-7:0], b[5:0]};
         dec_remaining = dec_remaining - 2'd1;
         if (dec_remaining == 2'd0) begin
            cp     = dec_partial;
            status = dec_cont_error ? STATUS_BAD_CONT : STATUS_OK;
            len    = dec_length;
            clear_decoder();
            emit_code_point(cp, status, len);
         end else if (last) begin
            len = dec_length - 3'(dec_remaining);
            clear_decoder();
            push_unit('0, STATUS_TRUNCATED, len, 1'b1);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: random stalls, an optional long hold-off, and the checker
   // ---------------------------------------------------------------------------------

   // The hold-off is counted here, so the request side keeps offering bytes meanwhile.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HoldCycles;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= IdlePercent);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got.unit        = rsp_unit;
         got.status      = rsp_status;
         got.consumed    = rsp_consumed_bytes;
         got.last_of_run = rsp_last_of_run;
         if (pending_units.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected result unit=%h status=%0d consumed=%0d last=%0b",
                        $realtime, got.unit, got.status, got.consumed, got.last_of_run);
         end else begin
            want = pending_units.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $write("%0t: mismatch expected unit=%h status=%0d consumed=%0d last=%0b",
                         $realtime, want.unit, want.status, want.consumed,
                         want.last_of_run);
                  $display(", got unit=%h status=%0d consumed=%0d last=%0b",
                           got.unit, got.status, got.consumed, got.last_of_run);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offers one byte and returns at the edge where it is taken. Valid stays high from one
   // request to the next unless random idle cycles drop it first. Called at a rising edge.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!no_idle && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      decode_byte(b, last);
   endtask

   // Ends the stream with an ASCII byte so no sequence stays open, then waits until every
   // result is out and the pipeline has emptied. The register may be written afterwards.
   task automatic close_and_drain();
      send_byte(8'h41, 1'b1);
      req_valid <= 1'b0;
      while (pending_units.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_format(input logic fmt);
      csr_write_enable <= 1'b1;
      csr_write_data   <= fmt;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      out_format = fmt;
   endtask

   // Mostly well-formed sequences with random payload bits; some have a damaged
   // continuation byte or stop early, the rest are arbitrary bytes. The end-of-stream
   // flag falls now and then, more often on the closing byte of a sequence.
   task automatic send_random_stream(input int n_bytes);
      int         sent;
      int         len;
      int         cut;
      logic [7:0] pattern[4];
      sent = 0;
      while (sent < n_bytes) begin
         if ($urandom_range(99) < 85) begin
            len = $urandom_range(1, 4);
            case (len)
               1:       pattern[0] = {1'b0, 7'($urandom)};
               2:       pattern[0] = {3'b110, 5'($urandom)};
               3:       pattern[0] = {4'b1110, 4'($urandom)};
               default: pattern[0] = {5'b11110, 3'($urandom)};
            endcase
            for (int k = 1; k < 4; k++) pattern[k] = {CONT_PREFIX, 6'($urandom)};
            if (len > 1 && $urandom_range(99) < 8)
               pattern[$urandom_range(1, len - 1)] = 8'($urandom);
            cut = len;
            if (len > 1 && $urandom_range(99) < 5) cut = $urandom_range(1, len - 1);
            for (int k = 0; k < cut; k++) begin
               send_byte(pattern[k], $urandom_range(99) < ((k == cut - 1) ? 8 : 2));
               sent++;
            end
         end else begin
            send_byte(8'($urandom), $urandom_range(99) < 10);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Single-byte characters at both ends of the ASCII range, one closing a stream.
   task automatic test_ascii_extremes();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h41, 1'b1);
   endtask

   // Two-, three- and four-byte sequences in UTF-32 mode, up to the largest 21-bit value.
   task automatic test_multibyte_utf32();
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
   endtask

   // Bad lead bytes, a bad continuation byte, and streams cut after one and after three
   // bytes of a sequence.
   task automatic test_error_cases();
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hC3, 1'b1);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // UTF-16 output: ordinary surrogate pairs, the largest value (whose high unit lands past
   // the high surrogate range), and a pair that carries a continuation error.
   task automatic test_surrogate_pairs();
      write_format(FORMAT_UTF16);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h3F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      close_and_drain();
   endtask

   // Random stream in UTF-32 mode with neither side ever pausing.
   task automatic test_random_steady_utf32();
      write_format(FORMAT_UTF32);
      no_idle = 1'b1;
      send_random_stream(350);
      close_and_drain();
      no_idle = 1'b0;
   endtask

   // The result side holds off for a long time while requests keep coming, so the block
   // fills up and must stall its input. The drain afterwards lets every result out
   // before anything new is offered.
   task automatic test_backpressure();
      write_format(FORMAT_UTF16);
      hold_request = 1'b1;
      send_random_stream(120);
      close_and_drain();
   endtask

   // Random streams with random idling on both sides, switching the output format.
   task automatic test_random_formats();
      send_random_stream(300);
      close_and_drain();
      write_format(FORMAT_UTF32);
      send_random_stream(250);
      close_and_drain();
      write_format(FORMAT_UTF16);
      send_random_stream(200);
      close_and_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_last_byte    = 1'b0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      fail_count       = 0;
      cycle_count      = 0;
      no_idle          = 1'b0;
      hold_request     = 1'b0;
      hold_left        = 0;
      out_format       = FORMAT_UTF32;
      clear_decoder();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ascii_extremes();
      test_multibyte_utf32();
      test_error_cases();
      close_and_drain();
      test_surrogate_pairs();
      test_random_steady_utf32();
      test_backpressure();
      test_random_formats();

      if (fail_count == 0 && pending_units.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
